@@ hdl/bresenham_line_stepper_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the line stepper.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_STEPPER_MACROS_SVH
`define BRESENHAM_LINE_STEPPER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BLSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/blsp_pkg.sv @@
// ----------------------------------------------------------------------------
// blsp_pkg
// Types and constants shared by the Bresenham line stepper modules.
// ----------------------------------------------------------------------------
package blsp_pkg;

  localparam int COORD_BITS = 12;
  localparam int DEC_BITS   = COORD_BITS + 3;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  typedef struct packed {
    logic   cmd;
    coord_t x_begin;
    coord_t y_begin;
    coord_t x_end;
    coord_t y_end;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last;
  } out_item_t;

  // A classified item as it waits between the front and the back.
  typedef struct packed {
    logic   is_start;
    coord_t x;
    coord_t y;
    coord_t major_end;
    dec_t   dec;
    dec_t   inc_keep;
    dec_t   inc_move;
    logic   steep;
    logic   minor_up;
    logic   last;
  } op_t;

endpackage

@@ hdl/bresenham_line_stepper.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// Integer Bresenham line generator, at most one pixel per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): a start item (cmd = start)
// carries both endpoints and yields the first pixel, taken from the endpoint
// with the smaller major coordinate. Each step item yields the next pixel;
// the final pixel has last set. A step item while no line is active yields
// nothing. A start item while a line is active abandons that line.
// Result channel (out_valid/out_ready/out_data): one pixel per result item.
// An accepted item is written into the queue; the back then takes it and
// registers its pixel in the result register. Throughput: one item per
// cycle while the receiver is ready, set by the single add and compare of
// the decision term in the back stage.
// A two-entry queue sits between the classifying front and the stepping back,
// so the input keeps taking items while a result waits; when the receiver
// stalls, at most two items plus the held result are buffered before in_ready
// drops. Reset (synchronous, rst_n low) empties the queue, drops out_valid and
// returns the stepper to idle.
// ----------------------------------------------------------------------------
module bresenham_line_stepper (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  blsp_pkg::in_item_t      in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output blsp_pkg::out_item_t     out_data
);
  import blsp_pkg::*;

  op_t  front_op;
  op_t  q_op;
  logic q_valid;
  logic q_ready;

  blsp_front u_front (
    .item (in_data),
    .op   (front_op)
  );

  blsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_op    (front_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_op     (q_op)
  );

  blsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_valid),
    .op_ready  (q_ready),
    .op        (q_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/blsp_front.sv @@
// ----------------------------------------------------------------------------
// blsp_front
// Classifies an incoming item and, for a start, works out the line setup.
// ----------------------------------------------------------------------------
module blsp_front (
  input  blsp_pkg::in_item_t item,
  output blsp_pkg::op_t      op
);
  import blsp_pkg::*;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic [COORD_BITS-1:0] major_abs;
  logic [COORD_BITS-1:0] minor_abs;
  logic [COORD_BITS-1:0] start_major;
  logic [DEC_BITS-1:0]   minor2;
  logic [DEC_BITS-1:0]   major1;
  logic                  steep;
  logic                  from_begin;

  always_comb begin
    dx  = $signed({1'b0, item.x_end}) - $signed({1'b0, item.x_begin});
    dy  = $signed({1'b0, item.y_end}) - $signed({1'b0, item.y_begin});
    adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    steep = ady > adx;

    major_abs  = steep ? ady : adx;
    minor_abs  = steep ? adx : ady;
    // The line always runs from the end with the smaller major coordinate.
    from_begin = steep ? !dy[COORD_BITS] : !dx[COORD_BITS];

    minor2 = {2'b00, minor_abs, 1'b0};
    major1 = {3'b000, major_abs};

    op.is_start  = (item.cmd == CMD_START);
    op.x         = from_begin ? item.x_begin : item.x_end;
    op.y         = from_begin ? item.y_begin : item.y_end;
    if (steep) begin
      op.major_end = from_begin ? item.y_end : item.y_begin;
    end else begin
      op.major_end = from_begin ? item.x_end : item.x_begin;
    end
    start_major  = steep ? op.y : op.x;
    op.dec       = $signed(minor2 - major1);
    op.inc_keep  = $signed(minor2);
    op.inc_move  = $signed(minor2 - {major1[DEC_BITS-2:0], 1'b0});
    op.steep     = steep;
    op.minor_up  = (dx != '0) && (dy != '0) && (dx[COORD_BITS] == dy[COORD_BITS]);
    op.last      = start_major >= op.major_end;
  end

endmodule

@@ hdl/blsp_queue.sv @@
// ----------------------------------------------------------------------------
// blsp_queue
// Two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module blsp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  blsp_pkg::op_t   push_op,
  output logic            pop_valid,
  input  logic            pop_ready,
  output blsp_pkg::op_t   pop_op
);
  import blsp_pkg::*;

  op_t        mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_op     = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

@@ hdl/blsp_back.sv @@
// ----------------------------------------------------------------------------
// blsp_back
// Holds the line state, steps it once per step item and registers the pixel.
// ----------------------------------------------------------------------------
module blsp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                op_valid,
  output logic                op_ready,
  input  blsp_pkg::op_t       op,
  output logic                out_valid,
  input  logic                out_ready,
  output blsp_pkg::out_item_t out_data
);
  import blsp_pkg::*;

  logic      busy_r, busy_nxt;
  coord_t    cur_x_r, cur_x_nxt;
  coord_t    cur_y_r, cur_y_nxt;
  coord_t    major_end_r, major_end_nxt;
  dec_t      dec_r, dec_nxt;
  dec_t      inc_keep_r, inc_keep_nxt;
  dec_t      inc_move_r, inc_move_nxt;
  logic      steep_r, steep_nxt;
  logic      minor_up_r, minor_up_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  logic      take;
  logic      move;
  coord_t    minor_step;
  coord_t    step_x;
  coord_t    step_y;
  logic      step_last;

  assign op_ready  = !out_valid_r || out_ready;
  assign take      = op_valid && op_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    // Shallow lines move the minor axis on a decision of zero, steep ones do not.
    move       = steep_r ? (!dec_r[DEC_BITS-1] && (dec_r != '0)) : !dec_r[DEC_BITS-1];
    minor_step = minor_up_r ? COORD_BITS'(1) : '1;
    if (steep_r) begin
      step_y    = cur_y_r + COORD_BITS'(1);
      step_x    = move ? cur_x_r + minor_step : cur_x_r;
      step_last = (step_y == major_end_r);
    end else begin
      step_x    = cur_x_r + COORD_BITS'(1);
      step_y    = move ? cur_y_r + minor_step : cur_y_r;
      step_last = (step_x == major_end_r);
    end

    busy_nxt      = busy_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    major_end_nxt = major_end_r;
    dec_nxt       = dec_r;
    inc_keep_nxt  = inc_keep_r;
    inc_move_nxt  = inc_move_r;
    steep_nxt     = steep_r;
    minor_up_nxt  = minor_up_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (take && op.is_start) begin
      busy_nxt      = !op.last;
      cur_x_nxt     = op.x;
      cur_y_nxt     = op.y;
      major_end_nxt = op.major_end;
      dec_nxt       = op.dec;
      inc_keep_nxt  = op.inc_keep;
      inc_move_nxt  = op.inc_move;
      steep_nxt     = op.steep;
      minor_up_nxt  = op.minor_up;
      out_nxt       = '{pixel_x: op.x, pixel_y: op.y, last: op.last};
      out_valid_nxt = 1'b1;
    end else if (take && busy_r) begin
      busy_nxt      = !step_last;
      cur_x_nxt     = step_x;
      cur_y_nxt     = step_y;
      dec_nxt       = dec_r + (move ? inc_move_r : inc_keep_r);
      out_nxt       = '{pixel_x: step_x, pixel_y: step_y, last: step_last};
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      major_end_r <= '0;
      dec_r       <= '0;
      inc_keep_r  <= '0;
      inc_move_r  <= '0;
      steep_r     <= 1'b0;
      minor_up_r  <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      major_end_r <= major_end_nxt;
      dec_r       <= dec_nxt;
      inc_keep_r  <= inc_keep_nxt;
      inc_move_r  <= inc_move_nxt;
      steep_r     <= steep_nxt;
      minor_up_r  <= minor_up_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

@@ hdl/blsp_checker.sv @@
// ----------------------------------------------------------------------------
// blsp_checker
// Port-level checks for the line stepper, bound to the top level.
// ----------------------------------------------------------------------------
`include "bresenham_line_stepper_macros.svh"

module blsp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input blsp_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input blsp_pkg::out_item_t out_data
);
  import blsp_pkg::*;

  logic in_stall;
  logic out_stall;

  assign in_stall  = in_valid && !in_ready;
  assign out_stall = out_valid && !out_ready;

  // A waiting input item must stay put until it is taken.
  `BLSP_ASSERT_NXT(a_in_hold, in_stall, in_valid && $stable(in_data), "held input changed")

  // A held result must not change or vanish before it is taken.
  `BLSP_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_data), "held result changed")

  // Input back-pressure only arises behind a stalled result.
  `BLSP_ASSERT_IMP(a_ready_stall, !in_ready, out_valid, "input stalled without a pending result")

  // The cycle after reset shows no result.
  `BLSP_ASSERT_IMP(a_reset_clear, $past(!rst_n), !out_valid, "result valid right after reset")

endmodule

bind bresenham_line_stepper blsp_checker u_blsp_checker (.*);

@@ sim/tb_bresenham_line_stepper.sv @@
// ----------------------------------------------------------------------------
// tb_bresenham_line_stepper
// Self-checking bench for the Bresenham line stepper. A line scoreboard keeps
// its own copy of the stepper state, predicts the pixel for each accepted item
// and compares every accepted result against the oldest prediction. Directed
// lines cover shallow, steep, diagonal and single-pixel lines, idle steps and
// abandoned lines; random lines with random idling on both channels follow.
// ----------------------------------------------------------------------------
module tb_bresenham_line_stepper;
  timeunit 1ns;
  timeprecision 1ps;

  import blsp_pkg::*;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int LONG_STEPS = 400;

  class line_scoreboard;
    logic      busy;
    coord_t    cur_x;
    coord_t    cur_y;
    coord_t    major_end;
    dec_t      decision;
    coord_t    abs_dx;
    coord_t    abs_dy;
    logic      steep;
    logic      minor_up;
    out_item_t pixels_due[$];
    int        pixels_predicted;
    int        errors;

    function new();
      busy = 1'b0;
      cur_x = '0;
      cur_y = '0;
      major_end = '0;
      decision = '0;
      abs_dx = '0;
      abs_dy = '0;
      steep = 1'b0;
      minor_up = 1'b0;
      pixels_predicted = 0;
      errors = 0;
    endfunction

    // Work out the pixel (if any) that an accepted item produces.
    function void note_item(in_item_t it);
      int        dx;
      int        dy;
      logic      fin;
      out_item_t px;
      if (it.cmd == CMD_START) begin
        dx = int'(it.x_end) - int'(it.x_begin);
        dy = int'(it.y_end) - int'(it.y_begin);
        abs_dx = coord_t'(dx < 0 ? -dx : dx);
        abs_dy = coord_t'(dy < 0 ? -dy : dy);
        minor_up = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
        steep = abs_dy > abs_dx;
        if (!steep) begin
          decision = dec_t'(2 * int'(abs_dy) - int'(abs_dx));
          if (dx >= 0) begin
            cur_x = it.x_begin;
            cur_y = it.y_begin;
            major_end = it.x_end;
          end else begin
            cur_x = it.x_end;
            cur_y = it.y_end;
            major_end = it.x_begin;
          end
          fin = cur_x >= major_end;
        end else begin
          decision = dec_t'(2 * int'(abs_dx) - int'(abs_dy));
          if (dy >= 0) begin
            cur_x = it.x_begin;
            cur_y = it.y_begin;
            major_end = it.y_end;
          end else begin
            cur_x = it.x_end;
            cur_y = it.y_end;
            major_end = it.y_begin;
          end
          fin = cur_y >= major_end;
        end
        busy = !fin;
      end else begin
        // A step with no active line leaves everything as it is.
        if (!busy) return;
        if (!steep) begin
          cur_x = cur_x + 1'b1;
          if (decision < 0) begin
            decision = dec_t'(int'(decision) + 2 * int'(abs_dy));
          end else begin
            cur_y = minor_up ? cur_y + 1'b1 : cur_y - 1'b1;
            decision = dec_t'(int'(decision) + 2 * (int'(abs_dy) - int'(abs_dx)));
          end
          fin = cur_x == major_end;
        end else begin
          cur_y = cur_y + 1'b1;
          if (decision <= 0) begin
            decision = dec_t'(int'(decision) + 2 * int'(abs_dx));
          end else begin
            cur_x = minor_up ? cur_x + 1'b1 : cur_x - 1'b1;
            decision = dec_t'(int'(decision) + 2 * (int'(abs_dx) - int'(abs_dy)));
          end
          fin = cur_y == major_end;
        end
        if (fin) busy = 1'b0;
      end
      px.pixel_x = cur_x;
      px.pixel_y = cur_y;
      px.last = fin;
      pixels_due.push_back(px);
      pixels_predicted++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d last=%0b", got.pixel_x, got.pixel_y, got.last);
        errors++;
        return;
      end
      want = pixels_due.pop_front();
      if (got.pixel_x !== want.pixel_x) begin
        $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
        errors++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  line_scoreboard sb;
  int             quiet_cycles = 0;
  bit             no_idle = 1'b0;
  bit             long_done = 1'b0;

  bresenham_line_stepper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one; none during a calm stretch.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic coord_t near_coord(coord_t c, int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Step items carry random endpoint fields that the block must ignore.
  task automatic send_steps(input int count);
    in_item_t it;
    repeat (count) begin
      it.cmd = CMD_STEP;
      it.x_begin = coord_t'($urandom);
      it.y_begin = coord_t'($urandom);
      it.x_end = coord_t'($urandom);
      it.y_end = coord_t'($urandom);
      send_item(it);
    end
  endtask

  task automatic draw(input coord_t x1, input coord_t y1, input coord_t x2,
                      input coord_t y2, input int steps);
    in_item_t it;
    it.cmd = CMD_START;
    it.x_begin = x1;
    it.y_begin = y1;
    it.x_end = x2;
    it.y_end = y2;
    send_item(it);
    send_steps(steps);
  endtask

  task automatic random_line();
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    int     r;
    int     span;
    int     ax;
    int     ay;
    int     len;
    int     steps;
    x1 = coord_t'($urandom);
    y1 = coord_t'($urandom);
    r = $urandom_range(0, 99);
    if (r < 2 && !long_done) begin
      // One line across the whole plane; only its first few hundred pixels are drawn.
      x2 = coord_t'($urandom);
      y2 = coord_t'($urandom);
      long_done = 1'b1;
    end else begin
      span = (r < 40) ? 3 : (r < 88) ? 24 : 200;
      x2 = near_coord(x1, span);
      y2 = near_coord(y1, span);
    end
    ax = int'(x2) - int'(x1);
    ay = int'(y2) - int'(y1);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    len = (ax > ay) ? ax : ay;
    if (len > LONG_STEPS) len = LONG_STEPS;
    r = $urandom_range(0, 99);
    if (r < 10 && len > 1) steps = $urandom_range(0, len - 1);
    else if (r < 16) steps = len + $urandom_range(1, 3);
    else steps = len;
    no_idle = ($urandom_range(0, 9) == 0);
    draw(x1, y1, x2, y2, steps);
  endtask

  // Acceptance monitor: notes inputs before checking results, and watches for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
          $display("FAIL bresenham_line_stepper");
          $finish;
        end
      end
    end
  end

  initial begin : ready_gen
    int n;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines.
    send_steps(1);
    draw(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1);
    draw(0, 0, 3, 0, 4);
    draw(COORD_MAX, 3, COORD_MAX, 0, 3);
    draw(3, 0, 0, 1, 3);
    draw(0, COORD_MAX, 2, COORD_MAX - 2, 2);
    // Lines abandoned by a new start while still being drawn.
    draw(0, 0, COORD_MAX, COORD_MAX, 1);
    draw(COORD_MAX, 0, 0, COORD_MAX, 1);
    draw(0, 0, 1, 3, 3);

    while (sb.pixels_predicted < 2000) random_line();
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS bresenham_line_stepper");
    end else begin
      $display("FAIL bresenham_line_stepper");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/blsp_pkg.sv
hdl/blsp_front.sv
hdl/blsp_queue.sv
hdl/blsp_back.sv
hdl/bresenham_line_stepper.sv
hdl/blsp_checker.sv
sim/tb_bresenham_line_stepper.sv
